// ===== hw/rtl/sac_pkg.sv =====
// ============================================================================
// sac_pkg
// Shared types, codes and arithmetic helpers for the subtitle compositor.
// ============================================================================
package sac_pkg;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_WIDTH  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_HEIGHT = 4'd1;

    localparam logic [CFG_DATA_W-1:0] ACTIVE_RESET = 10'd512;

    typedef enum logic [2:0] {
        OP_LOAD    = 3'd0,
        OP_INDEXED = 3'd1,
        OP_COVER   = 3'd2,
        OP_READ    = 3'd3,
        OP_CLEAR   = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_SKIP = 2'd1,
        ST_READ = 2'd2
    } status_t;

    // what the commit stage does with the current request
    typedef enum logic [2:0] {
        ACT_SKIP,
        ACT_LOADED,
        ACT_BLEND,
        ACT_READ,
        ACT_CLEAR
    } act_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ADDR,
        S_FETCH,
        S_MUL,
        S_WRITE
    } state_t;

    typedef struct packed {
        logic [2:0]         op;
        logic signed [11:0] pos_x;
        logic signed [11:0] pos_y;
        logic [7:0]         palette_index;
        logic [7:0]         coverage;
        logic [31:0]        color_word;
    } item_t;

    typedef struct packed {
        logic cap;
        logic addr_en;
        logic fetch_en;
        logic mul_en;
        logic commit;
        logic clr_en;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic out_free;
    } sts_t;

    // exact floor(v / 255) for v <= 255*255
    function automatic logic [7:0] div255(input logic [15:0] v);
        logic [16:0] t;
        t = 17'(v) + 17'(v[15:8]) + 17'd1;
        return t[15:8];
    endfunction

endpackage

// ===== hw/rtl/sac_in_if.sv =====
// ============================================================================
// sac_in_if
// Request channel: one compositor operation per transfer.
// ============================================================================
interface sac_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         op;
    logic signed [11:0] pos_x;
    logic signed [11:0] pos_y;
    logic [7:0]         palette_index;
    logic [7:0]         coverage;
    logic [31:0]        color_word;

    modport source (output valid, op, pos_x, pos_y, palette_index, coverage, color_word,
                    input ready);
    modport sink   (input valid, op, pos_x, pos_y, palette_index, coverage, color_word,
                    output ready);
endinterface

// ===== hw/rtl/sac_out_if.sv =====
// ============================================================================
// sac_out_if
// Result channel: read data and status for each request.
// ============================================================================
interface sac_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_pixel;
    logic [1:0]  status;

    modport source (output valid, read_pixel, status, input ready);
    modport sink   (input valid, read_pixel, status, output ready);
endinterface

// ===== hw/rtl/sac_cfg_if.sv =====
// ============================================================================
// sac_cfg_if
// Configuration write channel: register index and write data.
// ============================================================================
interface sac_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [sac_pkg::CFG_IDX_W-1:0]  index;
    logic [sac_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/sac_ctrl.sv =====
// ============================================================================
// sac_ctrl
// Sequencer: post-reset frame clear, then one request at a time through
// address, fetch, multiply and commit steps.
// ============================================================================
module sac_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output sac_pkg::cmd_t cmd,
    input  sac_pkg::sts_t sts
);

    sac_pkg::state_t state_reg;
    sac_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sac_pkg::S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sac_pkg::S_CLEAR:
            begin
                if (sts.clr_last)
                begin
                    state_next = sac_pkg::S_IDLE;
                end
            end
            sac_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = sac_pkg::S_ADDR;
                end
            end
            sac_pkg::S_ADDR:  state_next = sac_pkg::S_FETCH;
            sac_pkg::S_FETCH: state_next = sac_pkg::S_MUL;
            sac_pkg::S_MUL:   state_next = sac_pkg::S_WRITE;
            sac_pkg::S_WRITE:
            begin
                if (sts.out_free)
                begin
                    state_next = sac_pkg::S_IDLE;
                end
            end
            default: state_next = sac_pkg::S_CLEAR;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            sac_pkg::S_CLEAR: cmd.clr_en = 1'b1;
            sac_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.cap  = in_valid;
            end
            sac_pkg::S_ADDR:  cmd.addr_en  = 1'b1;
            sac_pkg::S_FETCH: cmd.fetch_en = 1'b1;
            sac_pkg::S_MUL:   cmd.mul_en   = 1'b1;
            sac_pkg::S_WRITE: cmd.commit   = sts.out_free;
            default:
            begin
                cmd      = '0;
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== hw/rtl/sac_datapath.sv =====
// ============================================================================
// sac_datapath
// Config registers, palette and frame memories, clip and address logic,
// alpha-over arithmetic and the result register.
// ============================================================================
module sac_datapath #(
    parameter int MAX_WIDTH     = 512,
    parameter int MAX_HEIGHT    = 512,
    parameter int PALETTE_DEPTH = 256
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  sac_pkg::cmd_t                  cmd,
    output sac_pkg::sts_t                  sts,
    input  sac_pkg::item_t                 item,
    input  logic                           cfg_we,
    input  logic [sac_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sac_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           out_ready,
    output logic                           out_valid,
    output logic [31:0]                    out_pixel,
    output logic [1:0]                     out_status
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int PW    = $clog2(PALETTE_DEPTH);

    // configuration
    logic [sac_pkg::CFG_DATA_W-1:0] aw_reg;
    logic [sac_pkg::CFG_DATA_W-1:0] ah_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            aw_reg <= sac_pkg::ACTIVE_RESET;
            ah_reg <= sac_pkg::ACTIVE_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == sac_pkg::CFG_ACTIVE_WIDTH)
            begin
                aw_reg <= cfg_data;
            end
            if (cfg_index == sac_pkg::CFG_ACTIVE_HEIGHT)
            begin
                ah_reg <= cfg_data;
            end
        end
    end

    // captured request
    sac_pkg::item_t item_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.cap)
        begin
            item_reg <= item;
        end
    end

    // clip and address
    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;
    logic          x_in;
    logic          y_in;
    logic [AW-1:0] addr_calc;
    logic          idx_ok;
    logic [7:0]    glob_a;

    always_comb
    begin
        w_eff  = (32'(aw_reg) > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(aw_reg);
        h_eff  = (32'(ah_reg) > 32'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(ah_reg);
        x_in   = !item_reg.pos_x[11] && (32'(item_reg.pos_x[10:0]) < 32'(w_eff));
        y_in   = !item_reg.pos_y[11] && (32'(item_reg.pos_y[10:0]) < 32'(h_eff));
        addr_calc = AW'(32'(item_reg.pos_y[10:0]) * 32'(w_eff) + 32'(item_reg.pos_x[10:0]));
        idx_ok = 32'(item_reg.palette_index) < 32'(PALETTE_DEPTH);
        glob_a = 8'hFF - item_reg.color_word[7:0];
    end

    logic [AW-1:0] addr_reg;
    logic          in_frame_reg;
    logic          idx_ok_reg;
    logic [15:0]   cov_prod_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.addr_en)
        begin
            addr_reg     <= addr_calc;
            in_frame_reg <= x_in && y_in;
            idx_ok_reg   <= idx_ok;
            cov_prod_reg <= 16'(glob_a) * 16'(item_reg.coverage);
        end
    end

    // palette memory, undefined until loaded
    logic [31:0] palette_mem [PALETTE_DEPTH];
    logic [31:0] pal_q_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.addr_en)
        begin
            if (item_reg.op == sac_pkg::OP_LOAD && idx_ok)
            begin
                palette_mem[item_reg.palette_index[PW-1:0]] <= item_reg.color_word;
            end
            pal_q_reg <= palette_mem[item_reg.palette_index[PW-1:0]];
        end
    end

    // frame memory with post-reset clear sweep
    logic [31:0]   frame_mem [DEPTH];
    logic [31:0]   px_reg;
    logic [AW-1:0] clr_cnt_reg;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [31:0]   mem_wd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clr_en)
        begin
            clr_cnt_reg <= clr_cnt_reg + AW'(1);
        end
    end

    assign sts.clr_last = (clr_cnt_reg == AW'(DEPTH - 1));

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            frame_mem[mem_wa] <= mem_wd;
        end
        if (cmd.fetch_en)
        begin
            px_reg <= frame_mem[addr_reg];
        end
    end

    // source color and action
    sac_pkg::act_t act_calc;
    logic [7:0]    fa_calc;
    logic [23:0]   rgb_calc;
    logic [7:0]    a_calc;

    always_comb
    begin
        fa_calc  = sac_pkg::div255(cov_prod_reg);
        act_calc = sac_pkg::ACT_SKIP;
        rgb_calc = item_reg.color_word[31:8];
        a_calc   = fa_calc;
        case (item_reg.op)
            sac_pkg::OP_LOAD:
            begin
                if (idx_ok_reg)
                begin
                    act_calc = sac_pkg::ACT_LOADED;
                end
            end
            sac_pkg::OP_INDEXED:
            begin
                rgb_calc = pal_q_reg[31:8];
                a_calc   = pal_q_reg[7:0];
                if (idx_ok_reg && pal_q_reg[7:0] != 8'd0 && in_frame_reg)
                begin
                    act_calc = sac_pkg::ACT_BLEND;
                end
            end
            sac_pkg::OP_COVER:
            begin
                // zero global alpha or coverage gives a zero product
                if (fa_calc != 8'd0 && in_frame_reg)
                begin
                    act_calc = sac_pkg::ACT_BLEND;
                end
            end
            sac_pkg::OP_READ:
            begin
                if (in_frame_reg)
                begin
                    act_calc = sac_pkg::ACT_READ;
                end
            end
            sac_pkg::OP_CLEAR:
            begin
                if (in_frame_reg)
                begin
                    act_calc = sac_pkg::ACT_CLEAR;
                end
            end
            default: act_calc = sac_pkg::ACT_SKIP;
        endcase
    end

    sac_pkg::act_t act_reg;
    logic [23:0]   rgb_reg;
    logic [7:0]    a_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.fetch_en)
        begin
            act_reg <= act_calc;
            rgb_reg <= rgb_calc;
            a_reg   <= a_calc;
        end
    end

    // products: c*a + p*(255-a) per channel, bg*(255-a) for alpha
    logic [7:0]  inv_a;
    logic [15:0] mix_r_reg;
    logic [15:0] mix_g_reg;
    logic [15:0] mix_b_reg;
    logic [15:0] mix_a_reg;
    logic        bg_zero_reg;

    assign inv_a = 8'hFF - a_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            mix_r_reg   <= 16'(rgb_reg[23:16]) * 16'(a_reg) + 16'(px_reg[31:24]) * 16'(inv_a);
            mix_g_reg   <= 16'(rgb_reg[15:8]) * 16'(a_reg) + 16'(px_reg[23:16]) * 16'(inv_a);
            mix_b_reg   <= 16'(rgb_reg[7:0]) * 16'(a_reg) + 16'(px_reg[15:8]) * 16'(inv_a);
            mix_a_reg   <= 16'(px_reg[7:0]) * 16'(inv_a);
            bg_zero_reg <= (px_reg[7:0] == 8'd0);
        end
    end

    logic [31:0] blend_px;

    always_comb
    begin
        if (bg_zero_reg)
        begin
            blend_px = {rgb_reg, a_reg};
        end
        else
        begin
            blend_px = {sac_pkg::div255(mix_r_reg), sac_pkg::div255(mix_g_reg),
                        sac_pkg::div255(mix_b_reg), a_reg + sac_pkg::div255(mix_a_reg)};
        end
    end

    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = addr_reg;
        mem_wd = blend_px;
        if (cmd.clr_en)
        begin
            mem_we = 1'b1;
            mem_wa = clr_cnt_reg;
            mem_wd = '0;
        end
        else if (cmd.commit)
        begin
            mem_we = (act_reg == sac_pkg::ACT_BLEND) || (act_reg == sac_pkg::ACT_CLEAR);
            mem_wd = (act_reg == sac_pkg::ACT_CLEAR) ? 32'd0 : blend_px;
        end
    end

    // result register
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [31:0] out_pixel_reg;
    logic [1:0]  out_status_reg;
    logic [1:0]  status_calc;

    always_comb
    begin
        case (act_reg)
            sac_pkg::ACT_LOADED: status_calc = sac_pkg::ST_DONE;
            sac_pkg::ACT_BLEND:  status_calc = sac_pkg::ST_DONE;
            sac_pkg::ACT_CLEAR:  status_calc = sac_pkg::ST_DONE;
            sac_pkg::ACT_READ:   status_calc = sac_pkg::ST_READ;
            default:             status_calc = sac_pkg::ST_SKIP;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_pixel_reg  <= (act_reg == sac_pkg::ACT_READ) ? px_reg : 32'd0;
            out_status_reg <= status_calc;
        end
    end

    assign sts.out_free = !out_valid_reg || out_ready;
    assign out_valid    = out_valid_reg;
    assign out_pixel    = out_pixel_reg;
    assign out_status   = out_status_reg;

endmodule

// ===== hw/rtl/subtitle_alpha_compositor_top.sv =====
// ============================================================================
// subtitle_alpha_compositor_top
// Palette / coverage alpha-over compositor into an RGBA frame store.
// ============================================================================
//  channel  | dir | payload                                         | moves
//  ---------+-----+-------------------------------------------------+-----------
//  in_ch    | in  | op, pos_x, pos_y, palette_index, coverage,      | request
//           |     | color_word                                      |
//  out_ch   | out | read_pixel, status                              | result
//  cfg      | in  | index, data                                     | reg write
//
//  The result goes valid once the request has passed the address and
//  palette read, frame fetch, multiply and commit steps; the next request is
//  accepted the cycle after commit, so no new request is taken before the
//  last one has committed: the sequencer holds one request at a time through
//  its read-modify-write of the frame memory.
//  After reset all MAX_WIDTH*MAX_HEIGHT words of the frame memory (262144 by
//  default) are cleared, one word per cycle; in_ch.ready stays low.
//  A stalled result holds in the output register; commit waits for it.
//  Config writes are taken every cycle.
// ============================================================================
module subtitle_alpha_compositor_top #(
    parameter int MAX_WIDTH     = 512,
    parameter int MAX_HEIGHT    = 512,
    parameter int PALETTE_DEPTH = 256
) (
    input  logic clk,
    input  logic rst_n,
    sac_in_if.sink    in_ch,
    sac_out_if.source out_ch,
    sac_cfg_if.sink   cfg
);

    sac_pkg::cmd_t  cmd;
    sac_pkg::sts_t  sts;
    sac_pkg::item_t item;

    assign item.op            = in_ch.op;
    assign item.pos_x         = in_ch.pos_x;
    assign item.pos_y         = in_ch.pos_y;
    assign item.palette_index = in_ch.palette_index;
    assign item.coverage      = in_ch.coverage;
    assign item.color_word    = in_ch.color_word;

    assign cfg.ready = 1'b1;

    sac_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    sac_datapath #(
        .MAX_WIDTH     (MAX_WIDTH),
        .MAX_HEIGHT    (MAX_HEIGHT),
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .item       (item),
        .cfg_we     (cfg.valid),
        .cfg_index  (cfg.index),
        .cfg_data   (cfg.data),
        .out_ready  (out_ch.ready),
        .out_valid  (out_ch.valid),
        .out_pixel  (out_ch.read_pixel),
        .out_status (out_ch.status)
    );

endmodule

// ===== hw/rtl/sac_checker.sv =====
// ============================================================================
// sac_checker
// Port-level checks on the compositor, bound to the top level.
// ============================================================================
module sac_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] read_pixel,
    input logic [1:0]  status
);

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(read_pixel) && $stable(status))
        else $error("result changed while stalled");

    // only a read reports pixel data
    a_pixel_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != sac_pkg::ST_READ |-> read_pixel == 32'd0)
        else $error("nonzero pixel on non-read result");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status != 2'd3)
        else $error("undefined status code");

    // one request in flight: no acceptance right after another
    a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while busy");

endmodule

bind subtitle_alpha_compositor_top sac_checker u_sac_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .read_pixel (out_ch.read_pixel),
    .status     (out_ch.status)
);
